>>> hdl/assert_macros.svh
// Shared assertion macros for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/ted_pkg.sv
`timescale 1ns / 1ps

package ted_pkg;

   // Mode register encodings; unused codes decode as ascii
   localparam logic [2:0] MODE_UTF8   = 3'd0;
   localparam logic [2:0] MODE_UCS_BE = 3'd1;
   localparam logic [2:0] MODE_UCS_LE = 3'd2;
   localparam logic [2:0] MODE_CP1252 = 3'd3;
   localparam logic [2:0] MODE_PALM   = 3'd4;
   localparam logic [2:0] MODE_ASCII  = 3'd5;

   localparam logic [15:0] UTF8_TWO_BYTE_MASK = 16'h07ff;

   // One decoded result of a step
   typedef struct packed {
      logic        emit;
      logic [15:0] code_unit;
      logic        too_long;
   } result_type;

   // Number of consecutive ones below bit 7 of a utf8 lead byte
   function automatic logic [2:0] lead_count(input logic [7:0] b);
      logic [2:0] n;
      logic       run;
      n   = 3'd0;
      run = 1'b1;
      for (int i = 6; i >= 0; i--) begin
         if (run && b[i]) begin
            n = n + 3'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

   // cp1252 upper control range; unassigned slots pass through
   function automatic logic [15:0] cp1252_map(input logic [7:0] b);
      logic [15:0] u;
      case (b)
         8'h80: u = 16'h20ac;
         8'h82: u = 16'h201a;
         8'h83: u = 16'h0192;
         8'h84: u = 16'h201e;
         8'h85: u = 16'h2026;
         8'h86: u = 16'h2020;
         8'h87: u = 16'h2021;
         8'h88: u = 16'h02c6;
         8'h89: u = 16'h2030;
         8'h8a: u = 16'h0160;
         8'h8b: u = 16'h2039;
         8'h8c: u = 16'h0152;
         8'h8e: u = 16'h017d;
         8'h91: u = 16'h2018;
         8'h92: u = 16'h2019;
         8'h93: u = 16'h201c;
         8'h94: u = 16'h201d;
         8'h95: u = 16'h2022;
         8'h96: u = 16'h2013;
         8'h97: u = 16'h2014;
         8'h98: u = 16'h02dc;
         8'h99: u = 16'h2122;
         8'h9a: u = 16'h0161;
         8'h9b: u = 16'h203a;
         8'h9c: u = 16'h0153;
         8'h9e: u = 16'h017e;
         8'h9f: u = 16'h0178;
         default: u = {8'h00, b};
      endcase
      return u;
   endfunction

endpackage

>>> hdl/ted_map.sv
`timescale 1ns / 1ps

// Single-byte table lookup for cp1252 and palm modes
module ted_map (
   input  logic [7:0]  map_byte,
   input  logic        palm,
   output logic [15:0] map_unit
);

   logic [15:0] cp_unit;

   assign cp_unit = ted_pkg::cp1252_map(map_byte);

   // palm table overrides cp1252
   always_comb begin
      map_unit = cp_unit;
      if (palm) begin
         case (map_byte)
            8'h18:   map_unit = 16'h2026;
            8'h19:   map_unit = 16'h2007;
            8'h8d:   map_unit = 16'h2662;
            8'h8e:   map_unit = 16'h2663;
            8'h8f:   map_unit = 16'h2661;
            8'h90:   map_unit = 16'h2660;
            default: map_unit = cp_unit;
         endcase
      end
   end

endmodule

>>> hdl/ted_decode.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Mode register, sequence state and per-byte decode
module ted_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [2:0]            csr_wr_data,
   input  logic                  step,
   input  logic [7:0]            step_byte,
   output ted_pkg::result_type   result
);

   logic [2:0]  mode_ff;
   logic [15:0] acc_ff, acc_in;
   logic [2:0]  remain_ff, remain_in;
   logic [2:0]  extra_ff, extra_in;
   logic        half_ff, half_in;

   logic [15:0] map_unit;
   logic [15:0] acc_shift;
   logic [2:0]  remain_dec;
   logic [2:0]  lead_n;

   ted_map u_map (
      .map_byte (step_byte),
      .palm     (mode_ff == ted_pkg::MODE_PALM),
      .map_unit (map_unit)
   );

   assign acc_shift  = {acc_ff[9:0], step_byte[5:0]};
   assign remain_dec = remain_ff - 3'd1;
   assign lead_n     = ted_pkg::lead_count(step_byte);

   // next state and result for the byte at hand
   always_comb begin
      acc_in           = acc_ff;
      remain_in        = remain_ff;
      extra_in         = extra_ff;
      half_in          = half_ff;
      result.emit      = 1'b1;
      result.code_unit = {8'h00, step_byte};
      result.too_long  = 1'b0;
      case (mode_ff)
         ted_pkg::MODE_UTF8: begin
            if (remain_ff != 3'd0) begin
               // continuation byte
               acc_in    = acc_shift;
               remain_in = remain_dec;
               if (remain_dec != 3'd0) begin
                  result.emit = 1'b0;
               end else begin
                  result.code_unit = acc_shift;
                  if (extra_ff == 3'd1) begin
                     result.code_unit = acc_shift & ted_pkg::UTF8_TWO_BYTE_MASK;
                  end else if (extra_ff >= 3'd3) begin
                     result.too_long = 1'b1;
                  end
                  acc_in   = 16'h0000;
                  extra_in = 3'd0;
               end
            end else if (step_byte[7] && lead_n != 3'd0) begin
               // lead byte opens a sequence
               acc_in      = {8'h00, step_byte};
               remain_in   = lead_n;
               extra_in    = lead_n;
               result.emit = 1'b0;
            end
         end
         ted_pkg::MODE_UCS_BE, ted_pkg::MODE_UCS_LE: begin
            if (!half_ff) begin
               acc_in      = {8'h00, step_byte};
               half_in     = 1'b1;
               result.emit = 1'b0;
            end else begin
               if (mode_ff == ted_pkg::MODE_UCS_BE) begin
                  result.code_unit = {acc_ff[7:0], step_byte};
               end else begin
                  result.code_unit = {step_byte, acc_ff[7:0]};
               end
               acc_in  = 16'h0000;
               half_in = 1'b0;
            end
         end
         ted_pkg::MODE_CP1252, ted_pkg::MODE_PALM: begin
            result.code_unit = map_unit;
         end
         default: begin
            result.code_unit = {8'h00, step_byte};
         end
      endcase
   end

   // state registers; a mode write drops any partial unit
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ted_pkg::MODE_UTF8;
         acc_ff    <= 16'h0000;
         remain_ff <= 3'd0;
         extra_ff  <= 3'd0;
         half_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff   <= csr_wr_data;
         acc_ff    <= 16'h0000;
         remain_ff <= 3'd0;
         extra_ff  <= 3'd0;
         half_ff   <= 1'b0;
      end else if (step) begin
         acc_ff    <= acc_in;
         remain_ff <= remain_in;
         extra_ff  <= extra_in;
         half_ff   <= half_in;
      end
   end

   `ASSERT_IMPL(a_remain_utf8, clock, reset, remain_ff != 3'd0, mode_ff == ted_pkg::MODE_UTF8, "continuation count outside utf8 mode")
   `ASSERT_IMPL(a_half_ucs, clock, reset, half_ff, mode_ff == ted_pkg::MODE_UCS_BE || mode_ff == ted_pkg::MODE_UCS_LE, "half unit held outside ucs16 mode")
   `ASSERT_IMPL(a_remain_le_extra, clock, reset, 1'b1, remain_ff <= extra_ff, "more bytes remaining than sequence length")

endmodule

>>> hdl/text_encoding_decoder_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// channel   direction  handshake             payload
// req       in         req_valid/req_stall   req_in_byte[7:0]
// rsp       out        rsp_valid/rsp_stall   rsp_code_unit[15:0], rsp_too_long
// csr       in         csr_wr_en             csr_wr_data[2:0] (mode)
//
// One byte per cycle while neither side stalls: a byte is registered in the input
// register, decoded by the state logic, and its code unit (if any) is then
// registered in the result register, which drives rsp_valid.
// Synchronous active-high reset clears the mode to utf8 and all sequence state.
// rsp_stall holds the result register; the input register still fills, and
// req_stall rises only when both registers hold an item.
module text_encoding_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_too_long
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_unit_ff;
   logic        out_long_ff;

   logic                out_free;
   logic                move;
   logic                req_take;
   ted_pkg::result_type result;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign move      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   ted_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (move),
      .step_byte   (in_byte_ff),
      .result      (result)
   );

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (move) begin
         in_valid_in = 1'b0;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = move && result.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      if (move && result.emit) begin
         out_unit_ff <= result.code_unit;
         out_long_ff <= result.too_long;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_code_unit = out_unit_ff;
   assign rsp_too_long  = out_long_ff;

   `ASSERT_NEXT(a_emit_shows, clock, reset, move && result.emit, rsp_valid, "emitted item not presented")
   `ASSERT_IMPL(a_stall_needs_item, clock, reset, req_stall, in_valid_ff && rsp_valid, "req stalled with a free pipeline")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, $stable(rsp_code_unit), "stalled item changed")

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // Unused mode codes; the block decodes them as ascii
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   localparam int LIMIT_CYCLES  = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int SEGMENTS      = 24;
   localparam int SEGMENT_ITEMS = 84;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        csr_wr_en     = 1'b0;
   logic [2:0]  csr_wr_data   = ted_pkg::MODE_UTF8;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte   = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [15:0] rsp_code_unit;
   logic        rsp_too_long;

   // Stimulus and scoreboard
   logic [7:0]           pending_bytes [$];
   ted_pkg::result_type  expected_units [$];
   logic                 req_fire       = 1'b0;
   int                   send_idle_pct  = 0;
   int                   rsp_stall_pct  = 0;
   int                   mismatch_count = 0;
   int                   cycle_count    = 0;

   // Predictor copy of the decoder state
   logic [2:0]  cur_mode  = ted_pkg::MODE_UTF8;
   logic [15:0] seq_acc   = 16'h0000;
   logic [2:0]  seq_left  = 3'd0;
   logic [2:0]  seq_len   = 3'd0;
   logic        pair_held = 1'b0;

   logic [2:0]  mode_order [8] = '{ted_pkg::MODE_UTF8, ted_pkg::MODE_UCS_BE,
                                   ted_pkg::MODE_UCS_LE, ted_pkg::MODE_CP1252,
                                   ted_pkg::MODE_PALM, ted_pkg::MODE_ASCII,
                                   MODE_SPARE_6, MODE_SPARE_7};

   text_encoding_decoder_unit dut (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_unit (rsp_code_unit),
      .rsp_too_long  (rsp_too_long)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // cp1252 upper control range; unassigned slots pass through
   function automatic logic [15:0] win1252_unit(input logic [7:0] b);
      logic [15:0] u;
      u = {8'h00, b};
      if (b[7:5] == 3'b100) begin
         case (b[4:0])
            5'h00: u = 16'h20ac;  5'h01: u = 16'h0081;  5'h02: u = 16'h201a;
            5'h03: u = 16'h0192;  5'h04: u = 16'h201e;  5'h05: u = 16'h2026;
            5'h06: u = 16'h2020;  5'h07: u = 16'h2021;  5'h08: u = 16'h02c6;
            5'h09: u = 16'h2030;  5'h0a: u = 16'h0160;  5'h0b: u = 16'h2039;
            5'h0c: u = 16'h0152;  5'h0d: u = 16'h008d;  5'h0e: u = 16'h017d;
            5'h0f: u = 16'h008f;  5'h10: u = 16'h0090;  5'h11: u = 16'h2018;
            5'h12: u = 16'h2019;  5'h13: u = 16'h201c;  5'h14: u = 16'h201d;
            5'h15: u = 16'h2022;  5'h16: u = 16'h2013;  5'h17: u = 16'h2014;
            5'h18: u = 16'h02dc;  5'h19: u = 16'h2122;  5'h1a: u = 16'h0161;
            5'h1b: u = 16'h203a;  5'h1c: u = 16'h0153;  5'h1d: u = 16'h009d;
            5'h1e: u = 16'h017e;  default: u = 16'h0178;
         endcase
      end
      return u;
   endfunction

   // Palm glyphs override cp1252
   function automatic logic [15:0] palm_unit(input logic [7:0] b);
      case (b)
         8'h18:   return 16'h2026;
         8'h19:   return 16'h2007;
         8'h8d:   return 16'h2662;
         8'h8e:   return 16'h2663;
         8'h8f:   return 16'h2661;
         8'h90:   return 16'h2660;
         default: return win1252_unit(b);
      endcase
   endfunction

   function automatic void clear_sequence();
      seq_acc   = 16'h0000;
      seq_left  = 3'd0;
      seq_len   = 3'd0;
      pair_held = 1'b0;
   endfunction

   // Expected code unit for one accepted byte; emit low when only collected
   function automatic ted_pkg::result_type decode_byte(input logic [7:0] b);
      ted_pkg::result_type r;
      int                  n;
      r      = '0;
      r.emit = 1'b1;
      case (cur_mode)
         ted_pkg::MODE_UTF8: begin
            if (seq_left != 3'd0) begin
               seq_acc  = {seq_acc[9:0], b[5:0]};
               seq_left = seq_left - 3'd1;
               if (seq_left != 3'd0) begin
                  r.emit = 1'b0;
               end else begin
                  r.code_unit = seq_acc;
                  if (seq_len == 3'd1) begin
                     r.code_unit = seq_acc & ted_pkg::UTF8_TWO_BYTE_MASK;
                  end else if (seq_len >= 3'd3) begin
                     r.too_long = 1'b1;
                  end
                  clear_sequence();
               end
            end else if (b[7]) begin
               n = 0;
               while (n < 7 && b[6 - n]) n++;
               if (n == 0) begin
                  r.code_unit = {8'h00, b};
               end else begin
                  seq_acc  = {8'h00, b};
                  seq_left = 3'(n);
                  seq_len  = 3'(n);
                  r.emit   = 1'b0;
               end
            end else begin
               r.code_unit = {8'h00, b};
            end
         end
         ted_pkg::MODE_UCS_BE, ted_pkg::MODE_UCS_LE: begin
            if (!pair_held) begin
               seq_acc   = {8'h00, b};
               pair_held = 1'b1;
               r.emit    = 1'b0;
            end else begin
               r.code_unit = (cur_mode == ted_pkg::MODE_UCS_BE) ?
                             {seq_acc[7:0], b} : {b, seq_acc[7:0]};
               clear_sequence();
            end
         end
         ted_pkg::MODE_CP1252: r.code_unit = win1252_unit(b);
         ted_pkg::MODE_PALM:   r.code_unit = palm_unit(b);
         default:              r.code_unit = {8'h00, b};
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input ted_pkg::result_type want);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at cycle %0d: %s: expected unit %h too_long %b,",
                  cycle_count, what, want.code_unit, want.too_long,
                  " got unit %h too_long %b", rsp_code_unit, rsp_too_long);
      end
   endtask

   // Driver: next byte goes out once the current one is taken
   always @(negedge clock) begin
      if (!req_valid || req_fire) begin
         if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_in_byte <= pending_bytes.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // Monitor: tracks mode writes, predicts accepted bytes, checks results
   always @(posedge clock) begin : monitor
      ted_pkg::result_type want;
      req_fire = 1'b0;
      if (!reset) begin
         if (csr_wr_en) begin
            cur_mode = csr_wr_data;
            clear_sequence();
         end
         if (req_valid && !req_stall) begin
            req_fire = 1'b1;
            want = decode_byte(req_in_byte);
            if (want.emit) expected_units.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_units.size() == 0) begin
               report_mismatch("result with none expected", '0);
            end else begin
               want = expected_units.pop_front();
               if (want.code_unit !== rsp_code_unit || want.too_long !== rsp_too_long) begin
                  report_mismatch("result differs", want);
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // Wait for every byte to be taken and every unit to come back
   task automatic drain(input int cycles);
      do @(posedge clock); while (pending_bytes.size() != 0 || req_valid);
      do @(negedge clock); while (expected_units.size() != 0);
      repeat (cycles) @(posedge clock);
   endtask

   task automatic set_mode(input logic [2:0] m);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Random bytes for one mode; utf8 gets mostly well-formed sequences
   task automatic queue_random(input logic [2:0] m, input int count);
      int         k;
      int         sel;
      int         n;
      logic [7:0] lead;
      k = 0;
      while (k < count) begin
         sel = $urandom_range(99);
         if (m == ted_pkg::MODE_UTF8) begin
            if (sel < 30) begin
               pending_bytes.push_back(8'($urandom_range(127)));
               k++;
            end else if (sel < 88) begin
               n = ($urandom_range(9) < 8) ? $urandom_range(3, 1) : $urandom_range(7, 4);
               lead = 8'($urandom_range(255));
               lead[7] = 1'b1;
               for (int i = 1; i <= n; i++) lead[7 - i] = 1'b1;
               if (n < 7) lead[6 - n] = 1'b0;
               pending_bytes.push_back(lead);
               for (int i = 0; i < n; i++) begin
                  if (sel < 82) pending_bytes.push_back({2'b10, 6'($urandom_range(63))});
                  else pending_bytes.push_back(8'($urandom_range(255)));
               end
               k += n + 1;
            end else begin
               pending_bytes.push_back(8'($urandom_range(255)));
               k++;
            end
         end else begin
            if (sel < 25) pending_bytes.push_back(8'($urandom_range(8'h9f, 8'h80)));
            else if (sel < 32) pending_bytes.push_back(8'($urandom_range(8'h19, 8'h18)));
            else pending_bytes.push_back(8'($urandom_range(255)));
            k++;
         end
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 20;
      rsp_stall_pct = 75;

      // Directed: field extremes, every mode, stray continuation, long sequence,
      // and a mode write that lands on a half-collected unit
      set_mode(ted_pkg::MODE_UTF8);
      pending_bytes = '{8'h00, 8'h7f, 8'h80, 8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac,
                        8'hf0, 8'h9f, 8'h98, 8'h80, 8'he2};
      drain(SETTLE_CYCLES);
      set_mode(ted_pkg::MODE_UCS_BE);
      pending_bytes = '{8'h12, 8'h34, 8'hab};
      drain(SETTLE_CYCLES);
      set_mode(ted_pkg::MODE_UCS_LE);
      pending_bytes = '{8'hff, 8'h01};
      drain(SETTLE_CYCLES);
      set_mode(ted_pkg::MODE_CP1252);
      pending_bytes = '{8'h80, 8'h81, 8'hff};
      drain(SETTLE_CYCLES);
      set_mode(ted_pkg::MODE_PALM);
      pending_bytes = '{8'h18, 8'h8e, 8'h9f};
      drain(SETTLE_CYCLES);
      set_mode(ted_pkg::MODE_ASCII);
      pending_bytes = '{8'hff};
      drain(SETTLE_CYCLES);
      set_mode(MODE_SPARE_6);
      pending_bytes = '{8'h80};
      drain(SETTLE_CYCLES);
      set_mode(MODE_SPARE_7);
      pending_bytes = '{8'hfe};
      drain(SETTLE_CYCLES);

      // Random segments: each idle profile sweeps every mode
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case (seg / 8)
            0:       begin send_idle_pct = 20; rsp_stall_pct = 75; end
            1:       begin send_idle_pct = 75; rsp_stall_pct = 20; end
            default: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
         endcase
         set_mode(mode_order[seg % 8]);
         queue_random(mode_order[seg % 8], SEGMENT_ITEMS);
         drain(SETTLE_CYCLES);
      end

      if (mismatch_count == 0 && expected_units.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
